// ===== rtl/hpc_pkg.sv =====
// Shared constants and types for the Hamiltonian path counter.
// No dependencies; imported by hamiltonian_path_counter, hpc_engine and the testbench.
package hpc_pkg;

  // Number of graph vertices and the fixed width of an edge row
  localparam int VERTICES  = 9;
  localparam int EDGE_BITS = 9;

  // Field widths of the stream channels
  localparam int VTX_IN_W  = 4;
  localparam int COUNT_W   = 19;
  localparam int IN_DATA_W = 16;
  localparam int OUT_DATA_W = 24;

  // Bits needed to hold n! (the largest possible path count)
  function automatic int fact_bits(input int n);
    longint f;
    f = 1;
    for (int i = 2; i <= n; i++) begin
      f = f * longint'(i);
    end
    return $clog2(f + 1);
  endfunction

  localparam int FACT_W   = fact_bits(VERTICES);
  localparam int TBL_W    = (FACT_W > COUNT_W) ? FACT_W : COUNT_W;
  localparam int SUBSETS  = 1 << VERTICES;
  localparam int TBL_DEPTH = SUBSETS * VERTICES;
  localparam int TBL_AW   = $clog2(TBL_DEPTH);
  localparam int VW       = $clog2(VERTICES);
  localparam int ROW_PAD_W = (VERTICES > EDGE_BITS) ? VERTICES : EDGE_BITS;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Out-neighbour rows of all vertices
  typedef logic [VERTICES-1:0][EDGE_BITS-1:0] edge_rows_t;

endpackage

// ===== rtl/hamiltonian_path_counter.sv =====
// Top level of the Hamiltonian path counter: stream ports, edge row store,
// output register. Depends on hpc_pkg and hpc_engine.
//
//   channel   dir  contents
//   s_axis    in   one out-neighbour row per request; tlast starts the count
//   m_axis    out  one path count per counted graph
//
// A row request without tlast is taken whenever s_axis_tready is high. A request
// with tlast stores its row and then runs the table sequencer, which scans every
// candidate predecessor of each subset endpoint with one table read each.
// s_axis_tready is low while the count runs and until its result enters the
// output register; a result waiting in the output register does not block new
// rows. Reset clears the rows to no edges.
module hamiltonian_path_counter
  import hpc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // row_vertex[3:0], row_edges[12:4]
  input  logic                  s_axis_tlast,   // last_row
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // path_count[18:0]
);

  logic                busy;
  logic                in_fire;
  logic [VTX_IN_W-1:0] row_vertex;
  logic [EDGE_BITS-1:0] row_edges;
  edge_rows_t          rows_q;
  logic                res_valid, res_ready;
  logic [COUNT_W-1:0]  res_count;
  logic                out_valid_q;
  logic [COUNT_W-1:0]  out_count_q;

  assign s_axis_tready = ~busy;
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign row_vertex    = s_axis_tdata[VTX_IN_W-1:0];
  assign row_edges     = s_axis_tdata[VTX_IN_W +: EDGE_BITS];

  // edge row store; out-of-range vertices store nothing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= '0;
    end else if (in_fire && (32'(row_vertex) < VERTICES)) begin
      rows_q[row_vertex[VW-1:0]] <= row_edges;
    end
  end

  hpc_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_fire & s_axis_tlast),
    .rows_i     (rows_q),
    .busy_o     (busy),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_count_o(res_count)
  );

  // output register
  assign res_ready = ~out_valid_q | m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_count_q <= res_count;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'(out_count_q);

endmodule

// ===== rtl/hpc_table_ram.sv =====
// Single-port-write, single-port-read RAM with registered read data.
// Holds the subset-by-endpoint path count table; no package dependency.
module hpc_table_ram #(
  parameter int DEPTH = 4608,
  parameter int WIDTH = 19
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/hpc_engine.sv =====
// Sequencer and shared adder that fill the path count table subset by subset.
// Depends on hpc_pkg and hpc_table_ram.
module hpc_engine
  import hpc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  edge_rows_t         rows_i,
  output logic               busy_o,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output logic [COUNT_W-1:0] res_count_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEL,
    ST_SCAN,
    ST_FLUSH,
    ST_WRITE,
    ST_DONE
  } state_e;

  localparam logic [VERTICES-1:0] FULL_SET = '1;
  localparam logic [VW-1:0]       LAST_V   = VW'(VERTICES - 1);

  state_e               state_q, state_d;
  logic [VERTICES-1:0]  s_q, s_d;
  logic [VW-1:0]        u_q, u_d;
  logic [VW-1:0]        v_q, v_d;
  logic                 take_q, take_d;
  logic [TBL_W-1:0]     acc_q, acc_d;
  logic [TBL_W-1:0]     tot_q, tot_d;

  logic [VERTICES-1:0]  u_bit;
  logic [VERTICES-1:0]  prev_set;
  logic [ROW_PAD_W-1:0] row_ext;
  logic [VERTICES-1:0]  row_use;
  logic                 edge_vu;
  logic                 singleton;
  logic [TBL_W-1:0]     wval;
  logic [TBL_W-1:0]     op_a, op_b, sum;
  logic [TBL_AW-1:0]    raddr, waddr;
  logic [TBL_W-1:0]     rdata;
  logic                 we;

  // current endpoint as a one-hot mask, and the subset without it
  assign u_bit    = VERTICES'(1) << u_q;
  assign prev_set = s_q & ~u_bit;

  // usable edges of vertex v: bits past the vertex count or the row width drop out
  assign row_ext = ROW_PAD_W'(rows_i[v_q]);
  assign row_use = row_ext[VERTICES-1:0];
  assign edge_vu = row_use[u_q];

  // a single-vertex subset seeds with one path
  assign singleton = (s_q == u_bit);
  assign wval      = singleton ? TBL_W'(1) : acc_q;

  // table addresses: subset * VERTICES + vertex
  assign raddr = TBL_AW'(prev_set) * TBL_AW'(VERTICES) + TBL_AW'(v_q);
  assign waddr = TBL_AW'(s_q) * TBL_AW'(VERTICES) + TBL_AW'(u_q);
  assign we    = (state_q == ST_WRITE);

  // shared adder: accumulates table reads, or adds a full-set entry to the total
  assign op_a = (state_q == ST_WRITE) ? tot_q : acc_q;
  assign op_b = (state_q == ST_WRITE) ? wval  : rdata;
  assign sum  = op_a + op_b;

  hpc_table_ram #(
    .DEPTH(TBL_DEPTH),
    .WIDTH(TBL_W)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wval),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // sequencer next state
  always_comb begin
    state_d = state_q;
    s_d     = s_q;
    u_d     = u_q;
    v_d     = v_q;
    take_d  = 1'b0;
    acc_d   = acc_q;
    tot_d   = tot_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          s_d     = VERTICES'(1);
          u_d     = '0;
          tot_d   = '0;
          state_d = ST_SEL;
        end
      end
      ST_SEL: begin
        if (s_q[u_q]) begin
          v_d     = '0;
          acc_d   = '0;
          state_d = ST_SCAN;
        end else if (u_q == LAST_V) begin
          u_d     = '0;
          s_d     = s_q + VERTICES'(1);
        end else begin
          u_d     = u_q + VW'(1);
        end
      end
      ST_SCAN: begin
        // predecessor v contributes when it is in the subset and has an edge to u
        take_d = prev_set[v_q] & edge_vu;
        if (take_q) begin
          acc_d = sum;
        end
        if (v_q == LAST_V) begin
          state_d = ST_FLUSH;
        end else begin
          v_d = v_q + VW'(1);
        end
      end
      ST_FLUSH: begin
        if (take_q) begin
          acc_d = sum;
        end
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        if (s_q == FULL_SET) begin
          tot_d = sum;
        end
        if (u_q == LAST_V) begin
          u_d = '0;
          if (s_q == FULL_SET) begin
            state_d = ST_DONE;
          end else begin
            s_d     = s_q + VERTICES'(1);
            state_d = ST_SEL;
          end
        end else begin
          u_d     = u_q + VW'(1);
          state_d = ST_SEL;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      take_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      take_q  <= take_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q   <= s_d;
    u_q   <= u_d;
    v_q   <= v_d;
    acc_q <= acc_d;
    tot_q <= tot_d;
  end

  // result, saturated to the output field
  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_count_o = (tot_q > TBL_W'(COUNT_MAX)) ? COUNT_MAX : tot_q[COUNT_W-1:0];

endmodule

// ===== dv/hamiltonian_path_counter_test.sv =====
// Self-checking stream testbench for hamiltonian_path_counter: loads digraph rows,
// predicts each Hamiltonian path count and compares it with every result.
// Depends on hpc_pkg and the hamiltonian_path_counter RTL.
module hamiltonian_path_counter_test
  import hpc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 25_000_000;

  // Tracks the adjacency rows and queues the path counts still to come
  class hamiltonian_tally;
    bit [EDGE_BITS-1:0] adjacency [VERTICES];
    longint unsigned    ways [SUBSETS][VERTICES];
    bit [COUNT_W-1:0]   expected_counts [$];
    int unsigned        failures;

    function new();
      foreach (adjacency[v]) adjacency[v] = '0;
      failures = 0;
    endfunction

    // Subset-by-endpoint DP over all visited sets, summed over the full set
    function bit [COUNT_W-1:0] tally_paths();
      int unsigned     full;
      int unsigned     usable;
      int unsigned     nb;
      longint unsigned total;
      full   = SUBSETS - 1;
      usable = (VERTICES < EDGE_BITS) ? full : (1 << EDGE_BITS) - 1;
      total  = 0;
      foreach (ways[s, v]) ways[s][v] = 0;
      for (int v = 0; v < VERTICES; v++) ways[1 << v][v] = 1;
      for (int s = 1; s < SUBSETS; s++) begin
        for (int v = 0; v < VERTICES; v++) begin
          if (((s >> v) & 1) == 0 || ways[s][v] == 0) continue;
          nb = usable & int'(adjacency[v]) & ~s & full;
          for (int u = 0; u < VERTICES; u++) begin
            if ((nb >> u) & 1) ways[s | (1 << u)][u] += ways[s][v];
          end
        end
      end
      for (int v = 0; v < VERTICES; v++) total += ways[full][v];
      if (total > COUNT_MAX) total = COUNT_MAX;
      return total[COUNT_W-1:0];
    endfunction

    // Accepted row request: store in-range rows, count on the last one
    function void note_row(bit [VTX_IN_W-1:0] vtx, bit [EDGE_BITS-1:0] edges,
                           bit last_row);
      if (vtx < VERTICES) adjacency[vtx] = edges;
      if (last_row) expected_counts.push_back(tally_paths());
    endfunction

    function void check_count(bit [COUNT_W-1:0] seen);
      bit [COUNT_W-1:0] want;
      if (expected_counts.size() == 0) begin
        $display("%0t: path count expected none, actual %0d", $time, seen);
        failures++;
      end else begin
        want = expected_counts.pop_front();
        if (want != seen) begin
          $display("%0t: path count expected %0d, actual %0d", $time, want, seen);
          failures++;
        end
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // row_vertex[3:0], row_edges[12:4]
  logic                  s_axis_tlast;   // last_row
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // path_count[18:0]

  hamiltonian_tally board = new();
  bit               calm = 1'b0;
  int unsigned      rows_sent = 0;
  int unsigned      graphs_sent = 0;
  int unsigned      cycles = 0;

  hamiltonian_path_counter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("hamiltonian_path_counter_test: FAIL");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_count(m_axis_tdata[COUNT_W-1:0]);
    end
  end

  // Receiver stalls in random bursts until the quiet tail of the run
  initial begin
    m_axis_tready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic pause(input int unsigned n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Hold off new rows until every queued count has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.expected_counts.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_row(input int unsigned vtx, input bit [EDGE_BITS-1:0] edges,
                          input bit last_row);
    logic [IN_DATA_W-1:0] word;
    word = '0;
    word[VTX_IN_W-1:0] = vtx[VTX_IN_W-1:0];
    word[VTX_IN_W +: EDGE_BITS] = edges;
    if (!calm && $urandom_range(0, 3) == 0) pause($urandom_range(1, 13));
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tlast  <= last_row;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_row(vtx[VTX_IN_W-1:0], edges, last_row);
    if (vtx < VERTICES || last_row) rows_sent++;
    if (last_row) graphs_sent++;
  endtask

  // Each edge set with probability density/4
  function automatic bit [EDGE_BITS-1:0] rand_row(input int unsigned density);
    bit [EDGE_BITS-1:0] r;
    for (int b = 0; b < EDGE_BITS; b++) r[b] = ($urandom_range(0, 3) < density);
    return r;
  endfunction

  // All rows in shuffled order, last flag on the final one
  task automatic send_graph(input int unsigned density);
    int unsigned order [VERTICES];
    int unsigned j;
    int unsigned t;
    foreach (order[i]) order[i] = i;
    for (int i = VERTICES - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < VERTICES; i++) begin
      send_row(order[i], rand_row(density), i == VERTICES - 1);
    end
  endtask

  initial begin
    int unsigned pick;
    int unsigned n;
    int unsigned density;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    rst_ni        <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty graph straight after reset
    send_row(0, '0, 1'b1);
    // Complete graph, self loops included
    for (int v = 0; v < VERTICES; v++) send_row(v, '1, v == VERTICES - 1);
    // Out-of-range vertices store nothing; the count still runs
    send_row(VERTICES, '0, 1'b0);
    send_row(15, '0, 1'b1);
    // Single chain 0 -> 1 -> ... -> 8 with a self loop on the tail
    for (int v = 0; v < VERTICES; v++) begin
      send_row(v, EDGE_BITS'((v == VERTICES - 1) ? (1 << v) : (1 << (v + 1))),
               v == VERTICES - 1);
    end
    wait_drained();

    // Random graphs, partial updates, abandoned sequences and noise
    rows_sent   = 0;
    graphs_sent = 0;
    while ((rows_sent < 130 || graphs_sent < 24) && graphs_sent < 40) begin
      if (rows_sent >= 110) calm = 1'b1;
      pick    = $urandom_range(0, 19);
      density = $urandom_range(1, 4);
      if (pick <= 11) begin
        send_graph(density);
      end else if (pick <= 15) begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
          send_row($urandom_range(0, VERTICES - 1), rand_row(density), i == n - 1);
        end
      end else if (pick <= 17) begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
          send_row($urandom_range(0, VERTICES - 1), rand_row(density), 1'b0);
        end
      end else if (pick == 18) begin
        send_row($urandom_range(0, 15), rand_row(density), $urandom_range(0, 3) == 0);
      end else if (!calm) begin
        wait_drained();
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.expected_counts.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (board.failures == 0 && board.expected_counts.size() == 0) begin
      $display("hamiltonian_path_counter_test: PASS");
    end else begin
      $display("hamiltonian_path_counter_test: FAIL");
    end
    $finish;
  end

endmodule
